@@ rtl/core/htu_pkg.sv @@
// ----------------------------------------------------------------------------
// htu_pkg
// shared types and constants of the homogeneous transform unit
// ----------------------------------------------------------------------------
package htu_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned CoefWidth  = 16;
  localparam int unsigned MatRegW    = 64;
  localparam int unsigned InvRegW    = 48;
  localparam int unsigned CfgIdxW    = 3;

  typedef enum logic [1:0] {
    REQ_POINT  = 2'd0,
    REQ_VECTOR = 2'd1,
    REQ_NORMAL = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAT_ROW0 = 3'd0,
    CFG_MAT_ROW1 = 3'd1,
    CFG_MAT_ROW2 = 3'd2,
    CFG_MAT_ROW3 = 3'd3,
    CFG_INV_ROW0 = 3'd4,
    CFG_INV_ROW1 = 3'd5,
    CFG_INV_ROW2 = 3'd6
  } cfg_idx_e;

endpackage

@@ rtl/core/homogeneous_transform_unit.sv @@
// ----------------------------------------------------------------------------
// homogeneous_transform_unit
// 4x4 homogeneous transform of points, vectors and normals in fixed point
// ----------------------------------------------------------------------------
// throughput: one item per cycle, set by the fully pipelined multiply array
//   and the one-bit-per-stage divider; busy never rises
// reset clears all valid bits and loads identity into both matrices
// the receiver cannot stall: each result shows for exactly one cycle
module homogeneous_transform_unit #(
  parameter int unsigned COORD_WIDTH = htu_pkg::CoordWidth,
  parameter int unsigned COEF_WIDTH  = htu_pkg::CoefWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item channel
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type_i,
  input  logic signed [COORD_WIDTH-1:0] in_x_i,
  input  logic signed [COORD_WIDTH-1:0] in_y_i,
  input  logic signed [COORD_WIDTH-1:0] in_z_i,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [htu_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [htu_pkg::MatRegW-1:0]   cfg_data_i,
  // result strobe
  output logic                          out_valid_o,
  output logic signed [COORD_WIDTH-1:0] out_x_o,
  output logic signed [COORD_WIDTH-1:0] out_y_o,
  output logic signed [COORD_WIDTH-1:0] out_z_o,
  output logic                          w_zero_o
);

  localparam int unsigned MW = htu_pkg::MatRegW;
  localparam int unsigned IW = htu_pkg::InvRegW;
  localparam int unsigned KF = COEF_WIDTH - 4;
  localparam int unsigned SW = COORD_WIDTH + COEF_WIDTH + 2;

  // the pipeline never holds off: every cycle can take a transfer
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // matrix registers, identity after reset
  // ---------------------------------------------------------------------------
  logic [MW-1:0] mat_q [4];
  logic [IW-1:0] inv_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        mat_q[i] <= (MW'(1) << KF) << (i * COEF_WIDTH);
      end
      for (int i = 0; i < 3; i++) begin
        inv_q[i] <= (IW'(1) << KF) << (i * COEF_WIDTH);
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        htu_pkg::CFG_MAT_ROW0: mat_q[0] <= cfg_data_i;
        htu_pkg::CFG_MAT_ROW1: mat_q[1] <= cfg_data_i;
        htu_pkg::CFG_MAT_ROW2: mat_q[2] <= cfg_data_i;
        htu_pkg::CFG_MAT_ROW3: mat_q[3] <= cfg_data_i;
        htu_pkg::CFG_INV_ROW0: inv_q[0] <= cfg_data_i[IW-1:0];
        htu_pkg::CFG_INV_ROW1: inv_q[1] <= cfg_data_i[IW-1:0];
        htu_pkg::CFG_INV_ROW2: inv_q[2] <= cfg_data_i[IW-1:0];
        default: ;  // writes past the last register are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input register stage
  // ---------------------------------------------------------------------------
  logic                              v0_q;
  htu_pkg::req_type_e                kind0_q;
  logic signed [2:0][COORD_WIDTH-1:0] crd0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    kind0_q   <= htu_pkg::req_type_e'(req_type_i);
    crd0_q[0] <= in_x_i;
    crd0_q[1] <= in_y_i;
    crd0_q[2] <= in_z_i;
  end

  // ---------------------------------------------------------------------------
  // coefficient select: normals use the transposed inverse
  // ---------------------------------------------------------------------------
  logic signed [3:0][2:0][COEF_WIDTH-1:0] coef;
  logic signed [3:0][COEF_WIDTH-1:0]      tcoef;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 3; j++) begin
        coef[r][j] = mat_q[r][j*COEF_WIDTH +: COEF_WIDTH];
      end
      tcoef[r] = mat_q[r][3*COEF_WIDTH +: COEF_WIDTH];
    end
    // row 3 only feeds w, which normals never use
    if (kind0_q == htu_pkg::REQ_NORMAL) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          coef[r][j] = inv_q[j][r*COEF_WIDTH +: COEF_WIDTH];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // multiply and row sums, then w handling and divide
  // ---------------------------------------------------------------------------
  logic                        mac_v;
  htu_pkg::req_type_e          mac_kind;
  logic signed [3:0][SW-1:0]   mac_sum;
  logic [2:0][COORD_WIDTH-1:0] res;

  htu_mac #(
    .COORD_WIDTH(COORD_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v0_q),
    .kind_i (kind0_q),
    .coord_i(crd0_q),
    .coef_i (coef),
    .tcoef_i(tcoef),
    .valid_o(mac_v),
    .kind_o (mac_kind),
    .sum_o  (mac_sum)
  );

  htu_div #(
    .COORD_WIDTH(COORD_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mac_v),
    .kind_i  (mac_kind),
    .sum_i   (mac_sum),
    .valid_o (out_valid_o),
    .res_o   (res),
    .w_zero_o(w_zero_o)
  );

  assign out_x_o = res[0];
  assign out_y_o = res[1];
  assign out_z_o = res[2];

endmodule

@@ rtl/core/htu_mac.sv @@
// ----------------------------------------------------------------------------
// htu_mac
// two-stage multiply and row sum of the 4x4 matrix product
// ----------------------------------------------------------------------------
module htu_mac #(
  parameter int unsigned COORD_WIDTH = htu_pkg::CoordWidth,
  parameter int unsigned COEF_WIDTH  = htu_pkg::CoefWidth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  htu_pkg::req_type_e                   kind_i,
  input  logic signed [2:0][COORD_WIDTH-1:0]   coord_i,
  input  logic signed [3:0][2:0][COEF_WIDTH-1:0] coef_i,
  input  logic signed [3:0][COEF_WIDTH-1:0]    tcoef_i,
  output logic                                 valid_o,
  output htu_pkg::req_type_e                   kind_o,
  output logic signed [3:0][COORD_WIDTH+COEF_WIDTH+1:0] sum_o
);

  localparam int unsigned PW   = COORD_WIDTH + COEF_WIDTH;
  localparam int unsigned SW   = PW + 2;
  localparam int unsigned FRAC = COORD_WIDTH / 2;

  logic                       v1_q, v2_q;
  htu_pkg::req_type_e         kind1_q, kind2_q;
  logic signed [PW-1:0]       prod_q [4][3];
  logic signed [COEF_WIDTH-1:0] t_q [4];
  logic signed [3:0][SW-1:0]  sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // products, the translation column only counts for points
  // packed elements select unsigned, so sign comes back before widening
  always_ff @(posedge clk_i) begin
    kind1_q <= kind_i;
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[r][j] <= PW'($signed(coef_i[r][j])) * PW'($signed(coord_i[j]));
      end
      t_q[r] <= (kind_i == htu_pkg::REQ_POINT) ? tcoef_i[r] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    kind2_q <= kind1_q;
    for (int r = 0; r < 4; r++) begin
      sum_q[r] <= SW'(prod_q[r][0]) + SW'(prod_q[r][1]) + SW'(prod_q[r][2])
                + (SW'(t_q[r]) <<< FRAC);
    end
  end

  assign valid_o = v2_q;
  assign kind_o  = kind2_q;
  assign sum_o   = sum_q;

endmodule

@@ rtl/core/htu_div.sv @@
// ----------------------------------------------------------------------------
// htu_div
// w handling, rounding and bit-per-stage pipelined divide by w
// ----------------------------------------------------------------------------
module htu_div #(
  parameter int unsigned COORD_WIDTH = htu_pkg::CoordWidth,
  parameter int unsigned COEF_WIDTH  = htu_pkg::CoefWidth
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  input  htu_pkg::req_type_e                            kind_i,
  input  logic signed [3:0][COORD_WIDTH+COEF_WIDTH+1:0] sum_i,
  output logic                                          valid_o,
  output logic [2:0][COORD_WIDTH-1:0]                   res_o,
  output logic                                          w_zero_o
);

  localparam int unsigned SW   = COORD_WIDTH + COEF_WIDTH + 2;
  localparam int unsigned MW   = SW - 1;
  localparam int unsigned FRAC = COORD_WIDTH / 2;
  localparam int unsigned KF   = COEF_WIDTH - 4;
  localparam int unsigned IB   = COORD_WIDTH - 1 - FRAC;
  localparam int unsigned DW   = MW + IB;
  localparam int unsigned XW   = MW - KF + 1;
  localparam int unsigned NS   = COORD_WIDTH;

  typedef struct packed {
    logic [2:0]                  neg;
    logic [2:0]                  ovf;
    logic [2:0][COORD_WIDTH-1:0] rnd;
    logic [2:0][DW-1:0]          rem;
    logic [2:0][COORD_WIDTH-1:0] quo;
    logic [DW-1:0]               dvs;
    logic                        wz;
    logic                        dv;
    logic                        zero;
  } lane_t;

  function automatic logic [COORD_WIDTH-1:0] sat_f(input logic neg, input logic [XW-1:0] m);
    logic [XW-1:0] lim;
    logic [XW-1:0] mm;
    lim = XW'(1) << (COORD_WIDTH - 1);
    if (!neg) begin
      mm = (m > lim - XW'(1)) ? lim - XW'(1) : m;
      return mm[COORD_WIDTH-1:0];
    end
    mm = (m > lim) ? lim : m;
    mm = XW'(0) - mm;
    return mm[COORD_WIDTH-1:0];
  endfunction

  function automatic lane_t step_f(input lane_t a);
    lane_t          b;
    logic [DW:0]    t;
    logic           ge;
    b = a;
    for (int r = 0; r < 3; r++) begin
      t  = {a.rem[r], 1'b0};
      ge = (t >= {1'b0, a.dvs});
      t  = ge ? (t - {1'b0, a.dvs}) : t;
      b.rem[r] = t[DW-1:0];
      b.quo[r] = {a.quo[r][COORD_WIDTH-2:0], ge};
    end
    return b;
  endfunction

  // entry stage: magnitudes, w checks, rounded bypass values
  lane_t          in_d;
  logic [2:0]     neg_s;
  logic [3:0][MW-1:0] mag_s;
  logic [SW-1:0]  abs_s;
  logic [XW-1:0]  m_s;
  logic           wneg_s, wz_s, wone_s, pt_s;

  always_comb begin
    in_d   = '0;
    neg_s  = '0;
    wneg_s = sum_i[3][SW-1];
    for (int r = 0; r < 4; r++) begin
      abs_s    = sum_i[r][SW-1] ? (~sum_i[r] + SW'(1)) : sum_i[r];
      mag_s[r] = abs_s[MW-1:0];
    end
    pt_s   = (kind_i == htu_pkg::REQ_POINT);
    wz_s   = pt_s && (mag_s[3] == '0);
    wone_s = pt_s && !wneg_s && (mag_s[3] == (MW'(1) << (FRAC + KF)));
    in_d.wz   = wz_s;
    in_d.dv   = pt_s && !wz_s && !wone_s;
    in_d.zero = wz_s || (kind_i == htu_pkg::REQ_NONE);
    in_d.dvs  = DW'(mag_s[3]) << IB;
    for (int r = 0; r < 3; r++) begin
      neg_s[r]     = sum_i[r][SW-1];
      m_s          = XW'(mag_s[r][MW-1:KF]) + XW'(mag_s[r][KF-1]);
      in_d.rnd[r]  = sat_f(neg_s[r], m_s);
      in_d.neg[r]  = neg_s[r] ^ wneg_s;
      in_d.ovf[r]  = (DW'(mag_s[r]) >= in_d.dvs);
      in_d.rem[r]  = DW'(mag_s[r]);
    end
  end

  lane_t        st_q [NS+1];
  logic [NS:0]  vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS-1:0], valid_i};
    end
  end

  // one quotient bit per stage
  always_ff @(posedge clk_i) begin
    st_q[0] <= in_d;
    for (int i = 0; i < NS; i++) begin
      st_q[i+1] <= step_f(st_q[i]);
    end
  end

  // final rounding of the quotient and result select
  logic [2:0][COORD_WIDTH-1:0] res_d;
  logic [COORD_WIDTH:0]        qp;
  lane_t                       fin;

  always_comb begin
    fin = st_q[NS];
    for (int r = 0; r < 3; r++) begin
      qp = {1'b0, fin.quo[r]} + (COORD_WIDTH+1)'(1);
      if (fin.zero) begin
        res_d[r] = '0;
      end else if (!fin.dv) begin
        res_d[r] = fin.rnd[r];
      end else if (fin.ovf[r]) begin
        res_d[r] = sat_f(fin.neg[r], '1);
      end else begin
        res_d[r] = sat_f(fin.neg[r], XW'(qp[COORD_WIDTH:1]));
      end
    end
  end

  logic                        ov_q;
  logic [2:0][COORD_WIDTH-1:0] res_q;
  logic                        wz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    wz_q  <= fin.wz;
  end

  assign valid_o  = ov_q;
  assign res_o    = res_q;
  assign w_zero_o = wz_q;

endmodule
